[rtl/core/quoted_printable_encoder_core_macros.svh]
// Assertion macros shared by the quoted-printable encoder core.
`ifndef QUOTED_PRINTABLE_ENCODER_CORE_MACROS_SVH
`define QUOTED_PRINTABLE_ENCODER_CORE_MACROS_SVH

// Implication in the same cycle, sampled on clk, off while in reset.
`define QPE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication into the following cycle.
`define QPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/qpe_pkg.sv]
// Types, constants and helpers shared by the quoted-printable encoder core.
`timescale 1ns / 1ps

package qpe_pkg;

	localparam logic [7:0] CHAR_EQ     = 8'h3D;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_TILDE  = 8'h7E;
	localparam logic [7:0] LIMIT_RESET = 8'd76;

	// command queue depth, a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// emission steps of one command
	localparam logic [2:0] STEP_SOFT_EQ = 3'd0;
	localparam logic [2:0] STEP_CR      = 3'd1;
	localparam logic [2:0] STEP_LF      = 3'd2;
	localparam logic [2:0] STEP_PART    = 3'd3;
	localparam logic [2:0] STEP_HEX_HI  = 3'd4;
	localparam logic [2:0] STEP_HEX_LO  = 3'd5;

	typedef struct packed {
		logic       lf;    // line feed: CR LF only
		logic       brk;   // soft break before the part
		logic       hex;   // part is '=' and two hex digits
		logic [7:0] data;  // raw byte
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10)
			ch = 8'h30 + {4'd0, nib};
		else
			ch = 8'h37 + {4'd0, nib};
		return ch;
	endfunction

	function automatic logic [2:0] start_step(input cmd_t c);
		logic [2:0] s;
		if (c.lf)
			s = STEP_CR;
		else if (c.brk)
			s = STEP_SOFT_EQ;
		else
			s = STEP_PART;
		return s;
	endfunction

	function automatic logic [2:0] end_step(input cmd_t c);
		logic [2:0] s;
		if (c.lf)
			s = STEP_LF;
		else if (c.hex)
			s = STEP_HEX_LO;
		else
			s = STEP_PART;
		return s;
	endfunction

endpackage

[rtl/core/qpe_front.sv]
// Front end: accepts input bytes, classifies them and tracks the line length.
`timescale 1ns / 1ps

module qpe_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      in_byte,
	input  qpe_pkg::qstat_t q_stat,
	output logic            push,
	output qpe_pkg::cmd_t   push_cmd
);

	logic [7:0] line_limit_q;
	logic [7:0] line_count_q;
	logic       is_lf;
	logic       printable;
	logic [1:0] plen;
	logic [8:0] sum;
	logic       brk;

	assign in_stall = q_stat.full;
	assign push     = in_valid && !in_stall;

	assign is_lf     = (in_byte == qpe_pkg::CHAR_LF);
	assign printable = (in_byte >= qpe_pkg::CHAR_SPACE) && (in_byte <= qpe_pkg::CHAR_TILDE)
		&& (in_byte != qpe_pkg::CHAR_EQ);
	assign plen      = printable ? 2'd1 : 2'd3;
	assign sum       = {1'b0, line_count_q} + {7'd0, plen};
	// compare is done on the unwrapped sum
	assign brk       = !is_lf && (sum >= {1'b0, line_limit_q});

	always_comb begin
		push_cmd.lf   = is_lf;
		push_cmd.brk  = brk;
		push_cmd.hex  = !printable;
		push_cmd.data = in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= qpe_pkg::LIMIT_RESET;
			line_count_q <= 8'd0;
		end else begin
			if (cfg_we)
				line_limit_q <= cfg_wdata;
			if (push) begin
				if (is_lf)
					line_count_q <= 8'd0;
				else if (brk)
					line_count_q <= {6'd0, plen};
				else
					line_count_q <= sum[7:0];
			end
		end
	end

endmodule

[rtl/core/qpe_queue.sv]
// Short command queue between the front end and the emitter.
`timescale 1ns / 1ps

`include "quoted_printable_encoder_core_macros.svh"

module qpe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  qpe_pkg::cmd_t   push_cmd,
	input  logic            pop,
	output qpe_pkg::cmd_t   head,
	output qpe_pkg::qstat_t q_stat
);

	qpe_pkg::cmd_t                 slot_q [qpe_pkg::QDEPTH];
	logic [qpe_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [qpe_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [qpe_pkg::QCNT_W-1:0]    count_q;

	assign head         = slot_q[rd_ptr_q];
	assign q_stat.valid = (count_q != '0);
	assign q_stat.full  = (count_q == qpe_pkg::QCNT_W'(qpe_pkg::QDEPTH));

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`QPE_ASSERT_SAME(a_no_push_full, q_stat.full, !push || pop, "push into full queue")
	`QPE_ASSERT_SAME(a_no_pop_empty, pop, q_stat.valid, "pop from empty queue")

endmodule

[rtl/core/qpe_back.sv]
// Emitter: walks each command through its output characters, one per cycle while out_stall is low.
`timescale 1ns / 1ps

`include "quoted_printable_encoder_core_macros.svh"

module qpe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  qpe_pkg::cmd_t   head,
	input  qpe_pkg::qstat_t q_stat,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            last
);

	qpe_pkg::cmd_t cmd_q;
	logic [2:0]    step_q;
	logic          busy_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          last_q;

	qpe_pkg::cmd_t cur;
	logic [2:0]    cur_step;
	logic          have;
	logic          adv;
	logic          fin;
	logic [7:0]    ch;

	assign cur      = busy_q ? cmd_q : head;
	assign cur_step = busy_q ? step_q : qpe_pkg::start_step(head);
	assign have     = busy_q || q_stat.valid;
	assign adv      = !out_valid_q || !out_stall;
	assign fin      = (cur_step == qpe_pkg::end_step(cur));
	assign pop      = adv && !busy_q && q_stat.valid;

	always_comb begin
		unique case (cur_step)
			qpe_pkg::STEP_SOFT_EQ: ch = qpe_pkg::CHAR_EQ;
			qpe_pkg::STEP_CR:      ch = qpe_pkg::CHAR_CR;
			qpe_pkg::STEP_LF:      ch = qpe_pkg::CHAR_LF;
			qpe_pkg::STEP_PART:    ch = cur.hex ? qpe_pkg::CHAR_EQ : cur.data;
			qpe_pkg::STEP_HEX_HI:  ch = qpe_pkg::hex_char(cur.data[7:4]);
			qpe_pkg::STEP_HEX_LO:  ch = qpe_pkg::hex_char(cur.data[3:0]);
			default:               ch = qpe_pkg::CHAR_EQ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv && have) begin
			out_byte_q <= ch;
			last_q     <= fin;
			cmd_q      <= cur;
			step_q     <= cur_step + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= have;
			if (have)
				busy_q <= !fin;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	`QPE_ASSERT_SAME(a_step_range, busy_q,
		(step_q != qpe_pkg::STEP_SOFT_EQ) && (step_q <= qpe_pkg::end_step(cmd_q)),
		"emitter step outside its command")
	`QPE_ASSERT_SAME(a_last_char, out_valid_q && last_q,
		(out_byte_q != qpe_pkg::CHAR_CR) && (out_byte_q != qpe_pkg::CHAR_EQ),
		"final character of a transaction is CR or '='")
	`QPE_ASSERT_NEXT(a_hold_busy, busy_q && out_valid_q && out_stall,
		busy_q && $stable(step_q), "emitter moved while output stalled")

endmodule

[rtl/core/quoted_printable_encoder_core.sv]
// Top level of the quoted-printable encoder core.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_stall    in_byte[7:0]
//  out      source     out_valid/out_stall  out_byte[7:0], last
//  cfg      sink       cfg_we               cfg_wdata[7:0] (line_limit)
//
// Each input transaction yields 1 to 6 output transactions, one per cycle
// while out_stall is low, as the emitter walks them: a plain printable byte
// yields one, a hex escape three, a soft break adds three, a line feed two.
// The front end takes a byte every cycle while the command queue has room.
// Reset clears the queue, the line count and the output valid flag; line_limit
// returns to 76. A stalled output holds its byte; the queue absorbs input.
`timescale 1ns / 1ps

module quoted_printable_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last
);

	qpe_pkg::qstat_t q_stat;
	qpe_pkg::cmd_t   push_cmd;
	qpe_pkg::cmd_t   head;
	logic            push;
	logic            pop;

	qpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	qpe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	qpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
